[hw/rtl/ecg_pkg.sv]
// Shared types, constants and constant tables for the earth-fixed to geodetic converter.
// Depends on nothing; every other file takes names from here by scope.
package ecg_pkg;

  localparam int unsigned MaxIterDefault = 20;
  localparam int unsigned CordSteps      = 60;

  localparam logic [63:0] PI_Q61  = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] MIN_C   = 64'h0100_0000_0000_0000;  // 2^56
  localparam logic [63:0] LAT_MAX = 64'h0000_005A_0000_0000;  // 90 deg << 32
  localparam logic signed [63:0] HALF_PI = signed'(PI_Q61 >> 2);
  localparam logic signed [63:0] PI_Q60  = signed'(PI_Q61 >> 1);
  localparam logic signed [63:0] TWO_PI  = signed'(PI_Q61);
  localparam logic signed [63:0] H_MAX   = 64'sh0000_00FF_FFFF_FFFF;
  localparam logic signed [63:0] H_MIN   = -64'sh0000_0100_0000_0000;

  localparam logic [6:0] DivSineSteps = 7'd60;
  localparam logic [6:0] DivRadSteps  = 7'd74;
  localparam logic [6:0] SqrtSteps    = 7'd60;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_FLAT   = 2'd1,
    REG_TOL    = 2'd2
  } cfg_reg_e;

  // right shift applied to a full product
  typedef enum logic [1:0] {
    SH_48 = 2'd0,
    SH_60 = 2'd1,
    SH_62 = 2'd2,
    SH_84 = 2'd3
  } mul_sh_e;

  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_mode_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_NORM = 2'd1,
    CS_ROT  = 2'd2
  } cord_state_e;

  typedef enum logic [5:0] {
    SQ_IDLE, SQ_E2, SQ_E2_W, SQ_LON_C, SQ_LON_CW, SQ_LON_M, SQ_LON_MW,
    SQ_T0, SQ_T0_W, SQ_PASS, SQ_CORD_W, SQ_MAG, SQ_MAG_W, SQ_SINE, SQ_SINE_W,
    SQ_SS, SQ_SS_W, SQ_ES, SQ_ES_W, SQ_CHK, SQ_SQRT, SQ_SQRT_W, SQ_NDIV,
    SQ_NDIV_W, SQ_NE, SQ_NE_W, SQ_NES, SQ_NES_W, SQ_UPD, SQ_LAT, SQ_LAT_W,
    SQ_LOND, SQ_LOND_W, SQ_DONE, SQ_FAIL
  } seq_state_e;

  // vectoring result: angle, raw or final length, normalization shift
  typedef struct packed {
    logic signed [63:0] ang;
    logic [63:0]        xmag;
    logic [5:0]         sh;
    logic               scaled;
  } cord_res_t;

  typedef logic signed [63:0] atan_tab_t [CordSteps];

  // restoring divide, elaboration only
  function automatic logic [127:0] cdiv(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q;
    logic [127:0] r;
    q = '0;
    r = '0;
    for (int k = 127; k >= 0; k--) begin
      r = {r[126:0], n[k]};
      if (r >= d) begin
        r    = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // digit-by-digit root of v * 4^extra, elaboration only
  function automatic logic [127:0] csqrt(input logic [63:0] v, input int extra);
    logic [127:0] root;
    logic [127:0] rem;
    logic [127:0] trial;
    logic [63:0]  vs;
    root = '0;
    rem  = '0;
    vs   = v;
    for (int j = 0; j < 32 + extra; j++) begin
      rem   = {rem[125:0], vs[63:62]};
      vs    = vs << 2;
      trial = {root[125:0], 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[126:0], 1'b1};
      end else begin
        root = {root[126:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t         tab;
    logic signed [63:0] s;
    logic [127:0]       term;
    int                 p;
    tab[0] = signed'(PI_Q61 >> 3);
    for (int i = 1; i < CordSteps; i++) begin
      s = '0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        p    = 60 - i * (2 * k + 1);
        term = cdiv(128'(1) << p, 128'(2 * k + 1));
        if ((k & 1) != 0) s = s - signed'(term[63:0]);
        else s = s + signed'(term[63:0]);
      end
      tab[i] = s;
    end
    return tab;
  endfunction

  function automatic logic [63:0] calc_inv_gain();
    logic [63:0]  k2;
    logic [127:0] q;
    k2 = ONE_Q60;
    for (int i = 0; i < 32; i++) k2 = k2 + (k2 >> (2 * i));
    q = cdiv(128'(1) << 120, csqrt(k2, 28));
    return q[63:0];
  endfunction

  function automatic logic [63:0] calc_deg_per_rad();
    logic [127:0] q;
    q = cdiv(128'(180) << 117, 128'(PI_Q61));
    return q[63:0];
  endfunction

  localparam atan_tab_t   ATAN_TAB    = build_atan();
  localparam logic [63:0] INV_GAIN    = calc_inv_gain();
  localparam logic [63:0] DEG_PER_RAD = calc_deg_per_rad();

endpackage

[hw/rtl/ecg_top.sv]
// Earth-fixed (mm) to geodetic latitude, longitude and height converter, top level.
// Sequencer around ecg_cordic, ecg_mul and ecg_dsq; types from ecg_pkg.
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i/in_ready_o   x_coord_i, y_coord_i, z_coord_i
//  out       source     out_valid_o/out_ready_i latitude_o, longitude_o, height_o,
//                                               iterations_o, error_o
//  cfg       sink       cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// Each refinement pass, the last one included, runs the 60-step CORDIC, the bit-serial
// square root and two bit-serial divides (74 and 60 steps); the 60-step divide is
// skipped when the sine is trivially zero or one.
// in_ready_o is high only while the sequencer is idle; a finished result waits
// in the output register and the next beat is taken meanwhile.
// Reset restores the ellipsoid registers; no memory to clear.
module ecef_to_geodetic_top #(
  parameter int unsigned MAX_ITERATIONS = ecg_pkg::MaxIterDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [46:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [40:0] x_coord_i,
  input  logic signed [40:0] y_coord_i,
  input  logic signed [40:0] z_coord_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [39:0] latitude_o,
  output logic [40:0]        longitude_o,
  output logic signed [40:0] height_o,
  output logic [6:0]         iterations_o,
  output logic               error_o
);

  localparam logic [6:0] MaxIter = 7'(MAX_ITERATIONS);

  ecg_pkg::seq_state_e state_q, state_d;

  // configuration
  logic [33:0] radius_q;
  logic [46:0] flat_q;
  logic [19:0] tol_q;

  // working registers
  logic signed [63:0] x_q, y_q, z_q, t_q, zt_q, lon_q, phi_q;
  logic [63:0]        e2_q, p_q, len_q, sine_q, tmp_q, n_q;
  logic [6:0]         iter_q;
  logic               final_q;
  logic signed [40:0] h_q;
  logic signed [39:0] lat_q;

  // output register
  logic               ovalid_q;
  logic signed [39:0] olat_q;
  logic [40:0]        olon_q;
  logic signed [40:0] oh_q;
  logic [6:0]         oiter_q;
  logic               oerr_q;

  // shared units
  logic                mul_start, mul_busy, mul_done;
  logic [63:0]         mul_a, mul_b, mul_res;
  ecg_pkg::mul_sh_e    mul_sh;
  logic                dsq_start, dsq_busy, dsq_done;
  ecg_pkg::ds_mode_e   dsq_mode;
  logic [63:0]         dsq_n, dsq_d, dsq_res;
  logic [6:0]          dsq_steps;
  logic                cord_start, cord_busy, cord_done;
  logic signed [63:0]  cord_a, cord_b;
  ecg_pkg::cord_res_t  cord_res;

  logic               accept, pass_ok, out_free;
  logic [63:0]        abs_z, abs_zt, abs_phi, c_val, mag_len, diff_abs, lim;
  logic signed [63:0] lon_sum, tn, diff, hfull, hsh;
  logic signed [40:0] zin;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !ovalid_q || out_ready_i;
  assign abs_z    = z_q[63] ? 64'(-z_q) : 64'(z_q);
  assign abs_zt   = zt_q[63] ? 64'(-zt_q) : 64'(zt_q);
  assign abs_phi  = phi_q[63] ? 64'(-phi_q) : 64'(phi_q);
  assign pass_ok  = final_q || (iter_q <= MaxIter);
  assign c_val    = ecg_pkg::ONE_Q60 - tmp_q;
  assign mag_len  = mul_res >> cord_res.sh;
  assign zin      = (z_coord_i == '0) ? 41'sd1 : z_coord_i;
  assign lim      = {28'd0, tol_q, 16'd0};

  // longitude fold into [0, 2pi)
  always_comb begin
    if (x_q[63]) lon_sum = cord_res.ang + (y_q[63] ? -ecg_pkg::PI_Q60 : ecg_pkg::PI_Q60);
    else         lon_sum = cord_res.ang;
  end

  // correction update
  assign tn       = zt_q[63] ? -signed'(tmp_q) : signed'(tmp_q);
  assign diff     = tn - t_q;
  assign diff_abs = diff[63] ? 64'(-diff) : 64'(diff);

  // height, rounded half up
  assign hfull = signed'(len_q) - signed'(n_q) + 64'sd32768;
  assign hsh   = hfull >>> 16;

  ecg_mul u_mul (
    .clk_i, .rst_ni,
    .start_i (mul_start), .a_i (mul_a), .b_i (mul_b), .sh_i (mul_sh),
    .busy_o  (mul_busy),  .done_o (mul_done), .res_o (mul_res)
  );

  ecg_dsq u_dsq (
    .clk_i, .rst_ni,
    .start_i (dsq_start), .mode_i (dsq_mode), .n_i (dsq_n), .d_i (dsq_d),
    .steps_i (dsq_steps), .busy_o (dsq_busy), .done_o (dsq_done), .res_o (dsq_res)
  );

  ecg_cordic u_cordic (
    .clk_i, .rst_ni,
    .start_i (cord_start), .a_i (cord_a), .b_i (cord_b),
    .busy_o  (cord_busy),  .done_o (cord_done), .res_o (cord_res)
  );

  // unit requests per state
  always_comb begin
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    mul_sh     = ecg_pkg::SH_48;
    dsq_start  = 1'b0;
    dsq_mode   = ecg_pkg::DS_DIV;
    dsq_n      = '0;
    dsq_d      = '0;
    dsq_steps  = ecg_pkg::DivSineSteps;
    cord_start = 1'b0;
    cord_a     = '0;
    cord_b     = '0;
    case (state_q)
      ecg_pkg::SQ_E2: begin
        mul_start = 1'b1;
        mul_a     = 64'(flat_q);
        mul_b     = (64'd1 << 49) - 64'(flat_q);
      end
      ecg_pkg::SQ_LON_C: begin
        cord_start = 1'b1;
        cord_a     = x_q[63] ? -x_q : x_q;
        cord_b     = x_q[63] ? -y_q : y_q;
      end
      ecg_pkg::SQ_LON_M, ecg_pkg::SQ_MAG: begin
        mul_start = 1'b1;
        mul_a     = cord_res.xmag;
        mul_b     = ecg_pkg::INV_GAIN;
        mul_sh    = ecg_pkg::SH_62;
      end
      ecg_pkg::SQ_T0: begin
        mul_start = 1'b1;
        mul_a     = abs_z;
        mul_b     = e2_q;
      end
      ecg_pkg::SQ_PASS: begin
        cord_start = pass_ok;
        cord_a     = signed'(p_q);
        cord_b     = z_q + t_q;
      end
      ecg_pkg::SQ_SINE: begin
        dsq_start = (abs_zt != '0) && (len_q > abs_zt);
        dsq_n     = abs_zt;
        dsq_d     = len_q;
      end
      ecg_pkg::SQ_SS: begin
        mul_start = 1'b1;
        mul_a     = sine_q;
        mul_b     = sine_q;
        mul_sh    = ecg_pkg::SH_60;
      end
      ecg_pkg::SQ_ES: begin
        mul_start = 1'b1;
        mul_a     = e2_q;
        mul_b     = tmp_q;
      end
      ecg_pkg::SQ_SQRT: begin
        dsq_start = 1'b1;
        dsq_mode  = ecg_pkg::DS_SQRT;
        dsq_n     = tmp_q;
        dsq_steps = ecg_pkg::SqrtSteps;
      end
      ecg_pkg::SQ_NDIV: begin
        dsq_start = 1'b1;
        dsq_n     = 64'(radius_q);
        dsq_d     = tmp_q;
        dsq_steps = ecg_pkg::DivRadSteps;
      end
      ecg_pkg::SQ_NE: begin
        mul_start = 1'b1;
        mul_a     = n_q;
        mul_b     = e2_q;
      end
      ecg_pkg::SQ_NES: begin
        mul_start = 1'b1;
        mul_a     = tmp_q;
        mul_b     = sine_q;
        mul_sh    = ecg_pkg::SH_60;
      end
      ecg_pkg::SQ_LAT: begin
        mul_start = 1'b1;
        mul_a     = abs_phi;
        mul_b     = ecg_pkg::DEG_PER_RAD;
        mul_sh    = ecg_pkg::SH_84;
      end
      ecg_pkg::SQ_LOND: begin
        mul_start = 1'b1;
        mul_a     = 64'(lon_q);
        mul_b     = ecg_pkg::DEG_PER_RAD;
        mul_sh    = ecg_pkg::SH_84;
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecg_pkg::SQ_IDLE:   if (accept) state_d = ecg_pkg::SQ_E2;
      ecg_pkg::SQ_E2:     state_d = ecg_pkg::SQ_E2_W;
      ecg_pkg::SQ_E2_W:   if (mul_done) state_d = ecg_pkg::SQ_LON_C;
      ecg_pkg::SQ_LON_C:  state_d = ecg_pkg::SQ_LON_CW;
      ecg_pkg::SQ_LON_CW: begin
        if (cord_done) state_d = cord_res.scaled ? ecg_pkg::SQ_LON_M : ecg_pkg::SQ_T0;
      end
      ecg_pkg::SQ_LON_M:  state_d = ecg_pkg::SQ_LON_MW;
      ecg_pkg::SQ_LON_MW: if (mul_done) state_d = ecg_pkg::SQ_T0;
      ecg_pkg::SQ_T0:     state_d = ecg_pkg::SQ_T0_W;
      ecg_pkg::SQ_T0_W:   if (mul_done) state_d = ecg_pkg::SQ_PASS;
      ecg_pkg::SQ_PASS:   state_d = pass_ok ? ecg_pkg::SQ_CORD_W : ecg_pkg::SQ_FAIL;
      ecg_pkg::SQ_CORD_W: begin
        if (cord_done) state_d = cord_res.scaled ? ecg_pkg::SQ_MAG : ecg_pkg::SQ_SINE;
      end
      ecg_pkg::SQ_MAG:    state_d = ecg_pkg::SQ_MAG_W;
      ecg_pkg::SQ_MAG_W:  if (mul_done) state_d = ecg_pkg::SQ_SINE;
      ecg_pkg::SQ_SINE:   state_d = dsq_start ? ecg_pkg::SQ_SINE_W : ecg_pkg::SQ_SS;
      ecg_pkg::SQ_SINE_W: if (dsq_done) state_d = ecg_pkg::SQ_SS;
      ecg_pkg::SQ_SS:     state_d = ecg_pkg::SQ_SS_W;
      ecg_pkg::SQ_SS_W:   if (mul_done) state_d = ecg_pkg::SQ_ES;
      ecg_pkg::SQ_ES:     state_d = ecg_pkg::SQ_ES_W;
      ecg_pkg::SQ_ES_W:   if (mul_done) state_d = ecg_pkg::SQ_CHK;
      ecg_pkg::SQ_CHK: begin
        if (tmp_q >= ecg_pkg::ONE_Q60 || c_val < ecg_pkg::MIN_C) state_d = ecg_pkg::SQ_FAIL;
        else state_d = ecg_pkg::SQ_SQRT;
      end
      ecg_pkg::SQ_SQRT:   state_d = ecg_pkg::SQ_SQRT_W;
      ecg_pkg::SQ_SQRT_W: if (dsq_done) state_d = ecg_pkg::SQ_NDIV;
      ecg_pkg::SQ_NDIV:   state_d = ecg_pkg::SQ_NDIV_W;
      ecg_pkg::SQ_NDIV_W: begin
        if (dsq_done) state_d = final_q ? ecg_pkg::SQ_LAT : ecg_pkg::SQ_NE;
      end
      ecg_pkg::SQ_NE:     state_d = ecg_pkg::SQ_NE_W;
      ecg_pkg::SQ_NE_W:   if (mul_done) state_d = ecg_pkg::SQ_NES;
      ecg_pkg::SQ_NES:    state_d = ecg_pkg::SQ_NES_W;
      ecg_pkg::SQ_NES_W:  if (mul_done) state_d = ecg_pkg::SQ_UPD;
      ecg_pkg::SQ_UPD:    state_d = ecg_pkg::SQ_PASS;
      ecg_pkg::SQ_LAT:    state_d = ecg_pkg::SQ_LAT_W;
      ecg_pkg::SQ_LAT_W:  if (mul_done) state_d = ecg_pkg::SQ_LOND;
      ecg_pkg::SQ_LOND:   state_d = ecg_pkg::SQ_LOND_W;
      ecg_pkg::SQ_LOND_W: if (mul_done) state_d = ecg_pkg::SQ_DONE;
      ecg_pkg::SQ_DONE:   if (out_free) state_d = ecg_pkg::SQ_IDLE;
      ecg_pkg::SQ_FAIL:   if (out_free) state_d = ecg_pkg::SQ_IDLE;
      default:            state_d = ecg_pkg::SQ_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ecg_pkg::SQ_IDLE;
      ovalid_q <= 1'b0;
      radius_q <= 34'd6378137000;
      flat_q   <= 47'd943732303791;
      tol_q    <= 20'd1;
    end else begin
      state_q <= state_d;
      if ((state_q == ecg_pkg::SQ_DONE || state_q == ecg_pkg::SQ_FAIL) && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ecg_pkg::REG_RADIUS: radius_q <= cfg_data_i[33:0];
          ecg_pkg::REG_FLAT:   flat_q   <= cfg_data_i;
          ecg_pkg::REG_TOL:    tol_q    <= cfg_data_i[19:0];
          default: ;
        endcase
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk_i) begin
    case (state_q)
      ecg_pkg::SQ_IDLE: begin
        if (accept) begin
          x_q     <= 64'(signed'({x_coord_i, 16'd0}));
          y_q     <= 64'(signed'({y_coord_i, 16'd0}));
          z_q     <= 64'(signed'({zin, 16'd0}));
          iter_q  <= '0;
          final_q <= 1'b0;
        end
      end
      ecg_pkg::SQ_E2_W: if (mul_done) e2_q <= mul_res;
      ecg_pkg::SQ_LON_CW: begin
        if (cord_done) begin
          lon_q <= lon_sum[63] ? lon_sum + ecg_pkg::TWO_PI : lon_sum;
          p_q   <= cord_res.xmag;
        end
      end
      ecg_pkg::SQ_LON_MW: if (mul_done) p_q <= mag_len;
      ecg_pkg::SQ_T0_W:   if (mul_done) t_q <= z_q[63] ? -signed'(mul_res) : signed'(mul_res);
      ecg_pkg::SQ_PASS:   zt_q <= z_q + t_q;
      ecg_pkg::SQ_CORD_W: begin
        if (cord_done) begin
          phi_q <= cord_res.ang;
          len_q <= cord_res.xmag;
        end
      end
      ecg_pkg::SQ_MAG_W:  if (mul_done) len_q <= mag_len;
      ecg_pkg::SQ_SINE: begin
        if (abs_zt == '0)         sine_q <= '0;
        else if (len_q <= abs_zt) sine_q <= ecg_pkg::ONE_Q60;
      end
      ecg_pkg::SQ_SINE_W: if (dsq_done) sine_q <= dsq_res;
      ecg_pkg::SQ_SS_W:   if (mul_done) tmp_q <= mul_res;
      ecg_pkg::SQ_ES_W:   if (mul_done) tmp_q <= mul_res;
      ecg_pkg::SQ_CHK:    tmp_q <= c_val;
      ecg_pkg::SQ_SQRT_W: if (dsq_done) tmp_q <= dsq_res;
      ecg_pkg::SQ_NDIV_W: if (dsq_done) n_q <= dsq_res;
      ecg_pkg::SQ_NE_W:   if (mul_done) tmp_q <= mul_res;
      ecg_pkg::SQ_NES_W:  if (mul_done) tmp_q <= mul_res;
      ecg_pkg::SQ_UPD: begin
        t_q    <= tn;
        iter_q <= iter_q + 7'd1;
        if (diff_abs <= lim) final_q <= 1'b1;
      end
      ecg_pkg::SQ_LAT: begin
        if (hsh > ecg_pkg::H_MAX)      h_q <= 41'(ecg_pkg::H_MAX);
        else if (hsh < ecg_pkg::H_MIN) h_q <= 41'(ecg_pkg::H_MIN);
        else                           h_q <= 41'(hsh);
      end
      ecg_pkg::SQ_LAT_W: begin
        if (mul_done) begin
          if (mul_res > ecg_pkg::LAT_MAX)
            lat_q <= phi_q[63] ? -40'(signed'(ecg_pkg::LAT_MAX)) : 40'(ecg_pkg::LAT_MAX);
          else
            lat_q <= phi_q[63] ? -40'(signed'(mul_res)) : 40'(mul_res);
        end
      end
      default: ;
    endcase
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (state_q == ecg_pkg::SQ_DONE) begin
        olat_q  <= lat_q;
        olon_q  <= mul_res[40:0];
        oh_q    <= h_q;
        oiter_q <= iter_q;
        oerr_q  <= 1'b0;
      end else if (state_q == ecg_pkg::SQ_FAIL) begin
        olat_q  <= '0;
        olon_q  <= '0;
        oh_q    <= '0;
        oiter_q <= iter_q;
        oerr_q  <= 1'b1;
      end
    end
  end

  assign in_ready_o   = (state_q == ecg_pkg::SQ_IDLE);
  assign out_valid_o  = ovalid_q;
  assign latitude_o   = olat_q;
  assign longitude_o  = olon_q;
  assign height_o     = oh_q;
  assign iterations_o = oiter_q;
  assign error_o      = oerr_q;

  // checks
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy) else $error("multiplier started while busy");

  a_dsq_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dsq_start |-> !dsq_busy) else $error("divide/root unit started while busy");

  a_cord_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_start |-> !cord_busy) else $error("cordic started while busy");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iterations_o <= MaxIter + 7'd1) else $error("pass count out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (latitude_o == '0 && longitude_o == '0 && height_o == '0))
    else $error("error beat carries nonzero result");

endmodule

[hw/rtl/ecg_mul.sv]
// Shared 64x64 multiplier built from four 32x32 partial products, one per cycle.
// Result is the product shifted right by a selectable amount. Uses ecg_pkg.
module ecg_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          a_i,
  input  logic [63:0]          b_i,
  input  ecg_pkg::mul_sh_e     sh_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [63:0]          res_o
);

  logic [63:0]       a_q, b_q, prod_q, prod_d;
  logic [127:0]      acc_q, acc_d, term;
  ecg_pkg::mul_sh_e  sh_q;
  logic [2:0]        cnt_q;
  logic              busy_q, done_q;
  logic [31:0]       op_a, op_b;

  // pick the partial product for this step
  always_comb begin
    case (cnt_q)
      3'd0:    begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
      3'd1:    begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
      3'd2:    begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
      default: begin op_a = a_q[63:32]; op_b = b_q[63:32]; end
    endcase
    prod_d = 64'(op_a) * 64'(op_b);
  end

  // weight the registered product from the previous step
  always_comb begin
    case (cnt_q)
      3'd1:    term = {64'd0, prod_q};
      3'd2:    term = {32'd0, prod_q, 32'd0};
      3'd3:    term = {32'd0, prod_q, 32'd0};
      3'd4:    term = {prod_q, 64'd0};
      default: term = '0;
    endcase
    acc_d = acc_q + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd4);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      sh_q  <= sh_i;
      acc_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

  always_comb begin
    case (sh_q)
      ecg_pkg::SH_48: res_o = acc_q[111:48];
      ecg_pkg::SH_60: res_o = acc_q[123:60];
      ecg_pkg::SH_62: res_o = acc_q[125:62];
      ecg_pkg::SH_84: res_o = {20'd0, acc_q[127:84]};
      default:        res_o = '0;
    endcase
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

[hw/rtl/ecg_dsq.sv]
// Shared bit-serial unit: restoring fractional divide or digit-by-digit square root,
// one result bit per cycle. Uses ecg_pkg for the mode code.
module ecg_dsq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ecg_pkg::ds_mode_e mode_i,
  input  logic [63:0]       n_i,      // dividend (below divisor) or radicand
  input  logic [63:0]       d_i,      // divisor
  input  logic [6:0]        steps_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [63:0]       res_o
);

  ecg_pkg::ds_mode_e mode_q;
  logic [65:0]       rem_q, rem_d, r2, trial;
  logic [63:0]       quo_q, quo_d, aux_q;
  logic [6:0]        cnt_q;
  logic              busy_q, done_q;

  // one step of divide or root
  always_comb begin
    if (mode_q == ecg_pkg::DS_SQRT) begin
      r2    = {rem_q[63:0], aux_q[63:62]};
      trial = {quo_q, 2'b01};
    end else begin
      r2    = {rem_q[64:0], 1'b0};
      trial = {2'b00, aux_q};
    end
    if (r2 >= trial) begin
      rem_d = r2 - trial;
      quo_d = {quo_q[62:0], 1'b1};
    end else begin
      rem_d = r2;
      quo_d = {quo_q[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      quo_q  <= '0;
      if (mode_i == ecg_pkg::DS_SQRT) begin
        rem_q <= '0;
        aux_q <= n_i;
      end else begin
        rem_q <= {2'b00, n_i};
        aux_q <= d_i;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (mode_q == ecg_pkg::DS_SQRT) aux_q <= aux_q << 2;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = quo_q;

endmodule

[hw/rtl/ecg_cordic.sv]
// Vectoring CORDIC: normalizes the vector, then 60 micro-rotations, one per cycle.
// Gives the angle and the unscaled length; uses ecg_pkg tables and types.
module ecg_cordic (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [63:0]        a_i,     // never negative
  input  logic signed [63:0]        b_i,
  output logic                      busy_o,
  output logic                      done_o,
  output ecg_pkg::cord_res_t        res_o
);

  ecg_pkg::cord_state_e state_q, state_d;
  logic signed [63:0]   x_q, y_q, z_q, dx, dy;
  logic [63:0]          m_q, abs_b;
  logic [5:0]           sh_q, i_q;
  logic                 scaled_q, done_q;
  logic [4:0]           nsh;

  assign abs_b = b_i[63] ? 64'(-b_i) : 64'(b_i);
  assign dx    = y_q >>> i_q;
  assign dy    = x_q >>> i_q;

  // normalization step size
  always_comb begin
    if (m_q[63:42] == '0)      nsh = 5'd16;
    else if (m_q[63:54] == '0) nsh = 5'd4;
    else                       nsh = 5'd1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecg_pkg::CS_IDLE: if (start_i && b_i != '0 && a_i != '0) state_d = ecg_pkg::CS_NORM;
      ecg_pkg::CS_NORM: if (m_q[63:58] != '0) state_d = ecg_pkg::CS_ROT;
      ecg_pkg::CS_ROT:  if (i_q == 6'(ecg_pkg::CordSteps - 1)) state_d = ecg_pkg::CS_IDLE;
      default:          state_d = ecg_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecg_pkg::CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ecg_pkg::CS_IDLE && start_i && (b_i == '0 || a_i == '0)) ||
                 (state_q == ecg_pkg::CS_ROT && i_q == 6'(ecg_pkg::CordSteps - 1));
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ecg_pkg::CS_IDLE: begin
        if (start_i) begin
          sh_q <= '0;
          i_q  <= '0;
          if (b_i == '0) begin
            x_q      <= a_i;
            z_q      <= '0;
            scaled_q <= 1'b0;
          end else if (a_i == '0) begin
            x_q      <= signed'(abs_b);
            z_q      <= b_i[63] ? -ecg_pkg::HALF_PI : ecg_pkg::HALF_PI;
            scaled_q <= 1'b0;
          end else begin
            x_q      <= a_i;
            y_q      <= b_i;
            z_q      <= '0;
            m_q      <= (abs_b > 64'(a_i)) ? abs_b : 64'(a_i);
            scaled_q <= 1'b1;
          end
        end
      end
      ecg_pkg::CS_NORM: begin
        if (m_q[63:58] == '0) begin
          x_q  <= x_q <<< nsh;
          y_q  <= y_q <<< nsh;
          m_q  <= m_q << nsh;
          sh_q <= sh_q + 6'(nsh);
        end
      end
      ecg_pkg::CS_ROT: begin
        if (!y_q[63]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + ecg_pkg::ATAN_TAB[i_q];
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - ecg_pkg::ATAN_TAB[i_q];
        end
        i_q <= i_q + 6'd1;
      end
      default: ;
    endcase
  end

  assign busy_o       = (state_q != ecg_pkg::CS_IDLE);
  assign done_o       = done_q;
  assign res_o.ang    = z_q;
  assign res_o.xmag   = 64'(x_q);
  assign res_o.sh     = sh_q;
  assign res_o.scaled = scaled_q;

endmodule

[verif/testbench.sv]
// Self-checking testbench for ecef_to_geodetic_top: random and directed positions,
// predicted in fixed point here and compared beat by beat. Depends on ecg_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  typedef struct {
    logic signed [40:0] x;
    logic signed [40:0] y;
    logic signed [40:0] z;
  } pos_t;

  typedef struct {
    logic signed [39:0] lat;
    logic [40:0]        lon;
    logic signed [40:0] hgt;
    logic [6:0]         iters;
    logic               err;
  } geo_t;

  localparam int MAX_ITERATIONS = ecg_pkg::MaxIterDefault;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  ecg_pkg::cfg_reg_e  cfg_idx_i = ecg_pkg::REG_RADIUS;
  logic [46:0]        cfg_data_i = '0;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [40:0] x_coord_i;
  logic signed [40:0] y_coord_i;
  logic signed [40:0] z_coord_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [39:0] latitude_o;
  logic [40:0]        longitude_o;
  logic signed [40:0] height_o;
  logic [6:0]         iterations_o;
  logic               error_o;

  ecef_to_geodetic_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .x_coord_i, .y_coord_i, .z_coord_i,
    .out_valid_o, .out_ready_i, .latitude_o, .longitude_o, .height_o,
    .iterations_o, .error_o
  );

  always #5 clk_i = ~clk_i;

  // shadow of the ellipsoid registers
  u64_t radius_mm = 64'd6378137000;
  u64_t flat_q48  = 64'd943732303791;
  u64_t tol_mm    = 64'd1;

  s64_t atan_lut [ecg_pkg::CordSteps];
  u64_t inv_gain_q62;
  u64_t deg_per_rad;

  pos_t pending_pos [$];
  geo_t expected_geo [$];
  int   errors = 0;

  // ---------------------------------------------------------------- arithmetic
  function automatic u64_t mul_shift(u64_t a, u64_t b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic u64_t frac_div(u64_t n, u64_t d, int fb);
    logic [127:0] q;
    q = ({64'd0, n} << fb) / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic u64_t int_sqrt(u64_t v, int extra);
    u64_t root, rem, trial, pair;
    root = 0;
    rem  = 0;
    for (int j = 0; j < 32 + extra; j++) begin
      pair = (j < 32) ? (v >> (62 - 2 * j)) & 64'd3 : 64'd0;
      rem  = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic u64_t mag_of(s64_t v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  // vectoring rotation: angle of (a, b) in Q60 radians, length in Q16 mm
  function automatic void vector_angle(input s64_t a, input s64_t b, output s64_t ang,
                                       output u64_t len);
    s64_t x, y, z, dx, dy;
    u64_t m;
    int   sh;
    if (b == 0) begin
      ang = 0;
      len = u64_t'(a);
    end else if (a == 0) begin
      ang = (b > 0) ? ecg_pkg::HALF_PI : -ecg_pkg::HALF_PI;
      len = mag_of(b);
    end else begin
      m  = (mag_of(b) > u64_t'(a)) ? mag_of(b) : u64_t'(a);
      sh = 0;
      while (m < (64'd1 << 58)) begin
        m = m << 1;
        sh++;
      end
      x = a <<< sh;
      y = b <<< sh;
      z = 0;
      for (int i = 0; i < ecg_pkg::CordSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx; y = y - dy; z = z + atan_lut[i];
        end else begin
          x = x - dx; y = y + dy; z = z - atan_lut[i];
        end
      end
      ang = z;
      len = mul_shift(u64_t'(x), inv_gain_q62, 62) >> sh;
    end
  endfunction

  function automatic u64_t sine_q60(s64_t zt, u64_t len);
    u64_t az;
    az = mag_of(zt);
    if (az == 0) return 0;
    if (len <= az) return ecg_pkg::ONE_Q60;
    return frac_div(az, len, 60);
  endfunction

  // prime-vertical radius in Q16 mm; returns 0 on a bad radicand
  function automatic bit vertical_radius(u64_t sine, u64_t e2, output u64_t n);
    u64_t es2, c;
    n   = 0;
    es2 = mul_shift(e2, mul_shift(sine, sine, 60), 48);
    if (es2 >= ecg_pkg::ONE_Q60) return 0;
    c = ecg_pkg::ONE_Q60 - es2;
    if (c < ecg_pkg::MIN_C) return 0;
    n = frac_div(radius_mm, int_sqrt(c, 28), 74);
    return 1;
  endfunction

  function automatic void build_luts();
    s64_t s, term;
    u64_t k2;
    atan_lut[0] = s64_t'(ecg_pkg::PI_Q61 >> 3);
    for (int i = 1; i < ecg_pkg::CordSteps; i++) begin
      s = 0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        term = s64_t'((64'd1 << (60 - i * (2 * k + 1))) / u64_t'(2 * k + 1));
        s = (k & 1) ? s - term : s + term;
      end
      atan_lut[i] = s;
    end
    k2 = ecg_pkg::ONE_Q60;
    for (int i = 0; i < 32; i++) k2 = k2 + (k2 >> (2 * i));
    inv_gain_q62 = frac_div(1, int_sqrt(k2, 28), 120);
    deg_per_rad  = frac_div(180, ecg_pkg::PI_Q61, 117);
  endfunction

  // full conversion of one position under the current register values
  function automatic geo_t to_geodetic(pos_t p);
    geo_t r;
    s64_t X, Y, Z, zmm, t, tn, lx, ly, base, lon, phi, h;
    u64_t e2, plen, len, sine, n, v, latd, lim;
    int   i;
    bit   ok;
    X = s64_t'(p.x) * 65536;
    Y = s64_t'(p.y) * 65536;
    zmm = s64_t'(p.z);
    if (zmm == 0) zmm = 1;
    Z = zmm * 65536;
    e2  = mul_shift(flat_q48, (64'd1 << 49) - flat_q48, 48);
    lim = tol_mm << 16;
    lx = X; ly = Y; base = 0;
    if (X < 0) begin
      lx = -X; ly = -Y;
      base = (Y >= 0) ? ecg_pkg::PI_Q60 : -ecg_pkg::PI_Q60;
    end
    vector_angle(lx, ly, lon, plen);
    lon = lon + base;
    if (lon < 0) lon = lon + ecg_pkg::TWO_PI;

    v  = mul_shift(mag_of(Z), e2, 48);
    t  = (Z < 0) ? -s64_t'(v) : s64_t'(v);
    ok = 1;
    i  = 0;
    // fixed-point refinement of the correction t
    forever begin
      if (i > MAX_ITERATIONS) begin ok = 0; break; end
      vector_angle(s64_t'(plen), Z + t, phi, len);
      sine = sine_q60(Z + t, len);
      if (!vertical_radius(sine, e2, n)) begin ok = 0; break; end
      v  = mul_shift(mul_shift(n, e2, 48), sine, 60);
      tn = (Z + t < 0) ? -s64_t'(v) : s64_t'(v);
      v  = mag_of(tn - t);
      t  = tn;
      i++;
      if (v <= lim) break;
    end
    if (ok) begin
      vector_angle(s64_t'(plen), Z + t, phi, len);
      sine = sine_q60(Z + t, len);
      ok = vertical_radius(sine, e2, n);
    end
    r.iters = 7'(i);
    if (!ok) begin
      r.lat = '0; r.lon = '0; r.hgt = '0; r.err = 1'b1;
      return r;
    end
    h = (s64_t'(len) - s64_t'(n) + 32768) >>> 16;
    if (h > ecg_pkg::H_MAX) h = ecg_pkg::H_MAX;
    if (h < ecg_pkg::H_MIN) h = ecg_pkg::H_MIN;
    latd = mul_shift(mag_of(phi), deg_per_rad, 84);
    if (latd > ecg_pkg::LAT_MAX) latd = ecg_pkg::LAT_MAX;
    r.lat = 40'((phi < 0) ? -latd : latd);
    r.lon = 41'(mul_shift(u64_t'(lon), deg_per_rad, 84));
    r.hgt = 41'(h);
    r.err = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------- idling
  bit steady_in = 0;
  bit steady_out = 0;

  function automatic int idle_len(ref bit steady);
    int pick;
    if ($urandom_range(0, 39) == 0) steady = ~steady;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // ---------------------------------------------------------------- driver
  int   in_gap;
  pos_t drv_pos;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      x_coord_i  <= '0;
      y_coord_i  <= '0;
      z_coord_i  <= '0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        drv_pos.x = x_coord_i; drv_pos.y = y_coord_i; drv_pos.z = z_coord_i;
        expected_geo.push_back(to_geodetic(drv_pos));
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pos.size() > 0) begin
          drv_pos = pending_pos.pop_front();
          x_coord_i  <= drv_pos.x;
          y_coord_i  <= drv_pos.y;
          z_coord_i  <= drv_pos.z;
          in_valid_i <= 1'b1;
          in_gap = idle_len(steady_in);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int   out_gap;
  geo_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_geo.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat lat=%0d lon=%0d h=%0d it=%0d err=%0b",
                   $time, latitude_o, longitude_o, height_o, iterations_o, error_o);
        end else begin
          want = expected_geo.pop_front();
          if (latitude_o !== want.lat) begin
            errors++;
            $display("%0t: latitude expected %0d actual %0d", $time, want.lat, latitude_o);
          end
          if (longitude_o !== want.lon) begin
            errors++;
            $display("%0t: longitude expected %0d actual %0d", $time, want.lon, longitude_o);
          end
          if (height_o !== want.hgt) begin
            errors++;
            $display("%0t: height expected %0d actual %0d", $time, want.hgt, height_o);
          end
          if (iterations_o !== want.iters) begin
            errors++;
            $display("%0t: iterations expected %0d actual %0d", $time, want.iters,
                     iterations_o);
          end
          if (error_o !== want.err) begin
            errors++;
            $display("%0t: error flag expected %0b actual %0b", $time, want.err, error_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = idle_len(steady_out);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(ecg_pkg::cfg_reg_e idx, u64_t val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 47'(val);
    case (idx)
      ecg_pkg::REG_RADIUS: radius_mm = val & ((64'd1 << 34) - 1);
      ecg_pkg::REG_FLAT:   flat_q48  = val & ((64'd1 << 47) - 1);
      ecg_pkg::REG_TOL:    tol_mm    = val & ((64'd1 << 20) - 1);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pos.size() != 0 || in_valid_i || expected_geo.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [40:0] rand_span(u64_t span);
    s64_t v;
    v = s64_t'({$urandom, $urandom}) % s64_t'(span);
    return 41'(v);
  endfunction

  function automatic pos_t rand_pos();
    pos_t p;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // around the earth's surface and orbit heights
      p.x = rand_span(64'd7000000000);
      p.y = rand_span(64'd7000000000);
      p.z = rand_span(64'd7000000000);
    end else if (pick < 85) begin
      p.x = 41'({$urandom, $urandom});
      p.y = 41'({$urandom, $urandom});
      p.z = 41'({$urandom, $urandom});
    end else begin
      p.x = rand_span(64'd2000);
      p.y = rand_span(64'd2000);
      p.z = rand_span(64'd2000);
    end
    if ($urandom_range(0, 19) == 0) p.z = '0;
    if ($urandom_range(0, 29) == 0) p.y = '0;
    if ($urandom_range(0, 29) == 0) p.x = '0;
    return p;
  endfunction

  task automatic add_pos(s64_t x, s64_t y, s64_t z);
    pos_t p;
    p.x = 41'(x); p.y = 41'(y); p.z = 41'(z);
    pending_pos.push_back(p);
  endtask

  task automatic run_setting(u64_t a, u64_t f, u64_t tol, int count);
    wait_drained();
    write_reg(ecg_pkg::REG_RADIUS, a);
    write_reg(ecg_pkg::REG_FLAT, f);
    write_reg(ecg_pkg::REG_TOL, tol);
    repeat (count) pending_pos.push_back(rand_pos());
  endtask

  localparam s64_t FMAX = (64'sd1 <<< 40) - 1;
  localparam s64_t FMIN = -(64'sd1 <<< 40);

  initial begin
    build_luts();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: axes, poles, zero z, origin and field extremes
    write_reg(ecg_pkg::REG_RADIUS, 64'd6378137000);
    write_reg(ecg_pkg::REG_FLAT, 64'd943732303791);
    write_reg(ecg_pkg::REG_TOL, 64'd1);
    add_pos(6378137000, 0, 0);
    add_pos(-6378137000, 0, 0);
    add_pos(0, 6378137000, 0);
    add_pos(0, -6378137000, 0);
    add_pos(0, 0, 6356752314);
    add_pos(0, 0, -6356752314);
    add_pos(0, 0, 0);
    add_pos(-4000000000, 0, 3000000000);
    add_pos(-4000000000, -1, 3000000000);
    add_pos(4510731000, 4510731000, 0);
    add_pos(-4510731000, -4510731000, -1);
    add_pos(1, 1, 1);
    add_pos(-1, -1, -1);
    add_pos(FMAX, FMAX, FMAX);
    add_pos(FMIN, FMIN, FMIN);
    add_pos(FMAX, FMIN, 0);
    add_pos(FMIN, FMAX, FMIN);
    add_pos(0, 0, FMAX);
    add_pos(3000000000, -2000000000, 5000000000);

    run_setting(64'd6378137000, 64'd943732303791, 64'd1, 500);
    run_setting(64'd6378137000, 64'd943732303791, 64'd1000000, 250);
    run_setting(64'd6378137000, 64'd0, 64'd1000, 150);
    run_setting(64'd1, 64'd943732303791, 64'd1, 100);
    run_setting((64'd1 << 34) - 1, (64'd1 << 47) - 1, 64'd1, 60);
    run_setting(64'd6378137000, (64'd1 << 47) - 1, 64'd500000, 100);
    run_setting(64'd6378388000, 64'd941486497013, 64'd10, 300);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // generous ceiling: every beat at the iteration limit plus the longest stalls
  initial begin
    #600_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
